[rtl/core/mosl_pkg.sv]
// Shared types and constants for the median-of-two-sorted-lists block.
package mosl_pkg;

    localparam int VAL_W = 32;
    localparam int RES_W = 33;

    typedef enum logic [1:0] {
        OP_PUSH_A = 2'd0,
        OP_PUSH_B = 2'd1,
        OP_MEDIAN = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [VAL_W-1:0] element_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] median_doubled;
        logic                    error_flag;
    } rsp_item_t;

    typedef struct packed {
        logic push;
        logic start;
        logic again;
        logic order;
        logic plan;
        logic read;
        logic eval;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic odd;
        logic base;
        logic second;
    } dp_status_t;

endpackage

[rtl/core/mosl_stream_if.sv]
// Valid/ready channel carrying one payload beat.
interface mosl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/mosl_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
module mosl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/core/mosl_dp.sv]
// Datapath: list stores, counts, selection window registers and result registers.
module mosl_dp #(
    parameter int LIST_CAPACITY = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mosl_pkg::dp_cmd_t                       cmd,
    input  logic [1:0]                              opcode,
    input  logic signed [mosl_pkg::VAL_W-1:0]       element_value,
    output mosl_pkg::dp_status_t                    status,
    output logic signed [mosl_pkg::RES_W-1:0]       median_doubled,
    output logic                                    error_flag
);
    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int KW = CW + 1;
    localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int VW = mosl_pkg::VAL_W;
    localparam int RW = mosl_pkg::RES_W;

    typedef enum logic [1:0] {
        MODE_DRAIN = 2'd0,
        MODE_MIN   = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic          ovf_reg;
    logic [CW-1:0] ps_reg, pn_reg, qs_reg, qn_reg;
    logic          p_is_b_reg;
    logic [KW-1:0] k_reg, xs_reg, ys_reg;
    mode_t         mode_reg;
    logic          pass_reg;
    logic          err_reg;
    logic signed [RW-1:0] acc_reg;
    logic signed [RW-1:0] med_reg;
    logic          flag_reg;

    logic [KW-1:0] total, half_total;
    logic          push_a, push_b, full_a, full_b;
    logic [CW-1:0] rem_p, rem_q;
    logic [KW-1:0] half_k, reach, xs_next, ys_next;
    logic [KW-1:0] p_idx, q_idx;
    logic [AW-1:0] addr_a, addr_b;
    logic [VW-1:0] rd_a, rd_b;
    logic signed [VW-1:0] p_data, q_data, pick;
    logic          p_less;

    assign total      = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign half_total = total >> 1;
    assign full_a     = (cnt_a_reg == CW'(LIST_CAPACITY));
    assign full_b     = (cnt_b_reg == CW'(LIST_CAPACITY));
    assign push_a     = cmd.push && (opcode == mosl_pkg::OP_PUSH_A);
    assign push_b     = cmd.push && (opcode == mosl_pkg::OP_PUSH_B);

    assign rem_p   = pn_reg - ps_reg;
    assign rem_q   = qn_reg - qs_reg;
    assign half_k  = k_reg >> 1;
    assign reach   = {1'b0, ps_reg} + half_k;
    assign xs_next = (reach >= {1'b0, pn_reg}) ? {1'b0, rem_p} : half_k;
    assign ys_next = k_reg - xs_next;

    always_comb
    begin
        unique case (mode_reg)
            MODE_DRAIN:
            begin
                p_idx = {1'b0, ps_reg};
                q_idx = {1'b0, qs_reg} + k_reg - KW'(1);
            end
            MODE_STEP:
            begin
                p_idx = {1'b0, ps_reg} + xs_reg - KW'(1);
                q_idx = {1'b0, qs_reg} + ys_reg - KW'(1);
            end
            default:
            begin
                p_idx = {1'b0, ps_reg};
                q_idx = {1'b0, qs_reg};
            end
        endcase
    end

    assign addr_a = cmd.read ? (p_is_b_reg ? q_idx[AW-1:0] : p_idx[AW-1:0])
                             : cnt_a_reg[AW-1:0];
    assign addr_b = cmd.read ? (p_is_b_reg ? p_idx[AW-1:0] : q_idx[AW-1:0])
                             : cnt_b_reg[AW-1:0];

    mosl_ram #(.WIDTH(VW), .DEPTH(LIST_CAPACITY)) u_ram_a (
        .clk     (clk),
        .wr_en   (push_a && !full_a),
        .wr_addr (addr_a),
        .wr_data (element_value),
        .rd_en   (cmd.read),
        .rd_addr (addr_a),
        .rd_data (rd_a)
    );

    mosl_ram #(.WIDTH(VW), .DEPTH(LIST_CAPACITY)) u_ram_b (
        .clk     (clk),
        .wr_en   (push_b && !full_b),
        .wr_addr (addr_b),
        .wr_data (element_value),
        .rd_en   (cmd.read),
        .rd_addr (addr_b),
        .rd_data (rd_b)
    );

    assign p_data = p_is_b_reg ? rd_b : rd_a;
    assign q_data = p_is_b_reg ? rd_a : rd_b;
    assign p_less = (p_data < q_data);

    always_comb
    begin
        unique case (mode_reg)
            MODE_MIN: pick = p_less ? p_data : q_data;
            default:  pick = q_data;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            if (push_a)
            begin
                if (full_a)
                    ovf_reg <= 1'b1;
                else
                    cnt_a_reg <= cnt_a_reg + CW'(1);
            end
            if (push_b)
            begin
                if (full_b)
                    ovf_reg <= 1'b1;
                else
                    cnt_b_reg <= cnt_b_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
                ovf_reg   <= 1'b0;
                flag_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.again)
        begin
            ps_reg     <= '0;
            pn_reg     <= cnt_a_reg;
            qs_reg     <= '0;
            qn_reg     <= cnt_b_reg;
            p_is_b_reg <= 1'b0;
            pass_reg   <= cmd.again;
            k_reg      <= (cmd.again || total[0]) ? half_total + KW'(1) : half_total;
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
            err_reg <= status.err;
        end
        if (cmd.order && (rem_p > rem_q))
        begin
            ps_reg     <= qs_reg;
            pn_reg     <= qn_reg;
            qs_reg     <= ps_reg;
            qn_reg     <= pn_reg;
            p_is_b_reg <= !p_is_b_reg;
        end
        if (cmd.plan)
        begin
            xs_reg <= xs_next;
            ys_reg <= ys_next;
            priority if ((ps_reg == pn_reg) || (k_reg == '0))
                mode_reg <= MODE_DRAIN;
            else if (k_reg == KW'(1))
                mode_reg <= MODE_MIN;
            else
                mode_reg <= MODE_STEP;
        end
        if (cmd.eval)
        begin
            if (mode_reg == MODE_STEP)
            begin
                if (p_less)
                begin
                    ps_reg <= CW'({1'b0, ps_reg} + xs_reg);
                    k_reg  <= k_reg - xs_reg;
                end
                else
                begin
                    qs_reg <= CW'({1'b0, qs_reg} + ys_reg);
                    k_reg  <= k_reg - ys_reg;
                end
            end
            else if (pass_reg)
                acc_reg <= acc_reg + {pick[VW-1], pick};
            else if (total[0])
                acc_reg <= {pick, 1'b0};
            else
                acc_reg <= {pick[VW-1], pick};
        end
        if (cmd.finish)
        begin
            med_reg <= acc_reg;
        end
    end

    assign status.err    = ovf_reg || (total == '0);
    assign status.odd    = total[0];
    assign status.base   = (mode_reg != MODE_STEP);
    assign status.second = pass_reg;

    assign median_doubled = med_reg;
    assign error_flag     = flag_reg;
endmodule

[rtl/core/mosl_ctrl.sv]
// Controller: command acceptance, selection sequencing and result register handshake.
module mosl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [1:0]           cmd_opcode,
    output logic                 cmd_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  mosl_pkg::dp_status_t status,
    output mosl_pkg::dp_cmd_t    dp_cmd
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ORDER  = 6'b000010,
        S_PLAN   = 6'b000100,
        S_READ   = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   take, out_free;

    assign cmd_ready = (state_reg == S_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next    = state_reg;
        dp_cmd        = '0;
        dp_cmd.push   = take && ((cmd_opcode == mosl_pkg::OP_PUSH_A) ||
                                 (cmd_opcode == mosl_pkg::OP_PUSH_B));
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && (cmd_opcode == mosl_pkg::OP_MEDIAN))
                begin
                    dp_cmd.start = 1'b1;
                    state_next   = status.err ? S_FINISH : S_ORDER;
                end
            end
            S_ORDER:
            begin
                dp_cmd.order = 1'b1;
                state_next   = S_PLAN;
            end
            S_PLAN:
            begin
                dp_cmd.plan = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                dp_cmd.read = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                dp_cmd.eval = 1'b1;
                if (!status.base)
                    state_next = S_ORDER;
                else if (status.odd || status.second)
                    state_next = S_FINISH;
                else
                begin
                    dp_cmd.again = 1'b1;
                    state_next   = S_ORDER;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    dp_cmd.finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.finish)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
endmodule

[rtl/core/median_of_two_sorted_lists.sv]
// Top level: median of two sorted lists, controller plus datapath.
//
// cmd channel: one beat per command. Opcode push A / push B appends the
// signed 32-bit element_value to that list; push to a full list is dropped
// and flags an error for the next compute. Opcode compute finds the median
// of both lists; the unused opcode is taken and ignored.
// rsp channel: one beat per compute, median_doubled (twice the median, 33
// bits signed) and error_flag (both lists empty or a push was dropped;
// median_doubled is then zero). Both lists are emptied by each compute.
// A compute that flags no error runs one or two k-th-smallest selections,
// each of about log2(k)+1 steps (order, plan, memory read, compare);
// after the last step the finish state moves the result into the output
// register once that register is free.
// cmd is not ready while a compute runs. A stalled rsp holds its beat;
// pushes are still taken, and a further compute waits at its end until
// the output register is free.
// Reset empties both lists and clears the error; RAM contents are not cleared.
module median_of_two_sorted_lists #(
    parameter int LIST_CAPACITY = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    mosl_stream_if.sink   cmd,
    mosl_stream_if.source rsp
);
    mosl_pkg::dp_cmd_t    dp_cmd;
    mosl_pkg::dp_status_t dp_status;

    mosl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.payload.opcode),
        .cmd_ready  (cmd.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .status     (dp_status),
        .dp_cmd     (dp_cmd)
    );

    mosl_dp #(.LIST_CAPACITY(LIST_CAPACITY)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .opcode         (cmd.payload.opcode),
        .element_value  (cmd.payload.element_value),
        .status         (dp_status),
        .median_doubled (rsp.payload.median_doubled),
        .error_flag     (rsp.payload.error_flag)
    );
endmodule

[bench/median_checker.sv]
// Median checker: predicts twice-median results from command beats and compares response beats.
module median_checker
    import mosl_pkg::*;
#(
    parameter int LIST_CAPACITY = 1024
) (
    input  logic   clk,
    input  logic   rst_n,
    mosl_stream_if cmd,
    mosl_stream_if rsp,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [VAL_W-1:0] list_a [LIST_CAPACITY];
    logic signed [VAL_W-1:0] list_b [LIST_CAPACITY];
    int unsigned             count_a = 0;
    int unsigned             count_b = 0;
    bit                      push_dropped = 1'b0;
    int                      error_total = 0;
    rsp_item_t               expected_medians [$];

    function automatic logic signed [VAL_W-1:0] entry(bit from_b, int unsigned idx);
        if (idx >= LIST_CAPACITY)
        begin
            return '0;
        end
        return from_b ? list_b[idx] : list_a[idx];
    endfunction

    // k-th smallest of both lists; the shorter remainder is always the probed one
    function automatic logic signed [VAL_W-1:0] kth_smallest(int unsigned k);
        bit                      p_b;
        bit                      done;
        int unsigned             ps, pn, qs, qn, t, half, xs, ys;
        logic signed [VAL_W-1:0] x, y, found;
        p_b = 1'b0;
        done = 1'b0;
        ps = 0;
        pn = count_a;
        qs = 0;
        qn = count_b;
        found = '0;
        while (!done)
        begin
            if (pn - ps > qn - qs)
            begin
                p_b = !p_b;
                t = ps; ps = qs; qs = t;
                t = pn; pn = qn; qn = t;
            end
            if (ps == pn || k == 0)
            begin
                found = entry(!p_b, qs + k - 1);
                done = 1'b1;
            end
            else if (k == 1)
            begin
                x = entry(p_b, ps);
                y = entry(!p_b, qs);
                found = (x < y) ? x : y;
                done = 1'b1;
            end
            else
            begin
                half = k / 2;
                xs = (ps + half >= pn) ? pn - ps : half;
                ys = k - xs;
                if (entry(p_b, ps + xs - 1) < entry(!p_b, qs + ys - 1))
                begin
                    ps += xs;
                    k -= xs;
                end
                else
                begin
                    qs += ys;
                    k -= ys;
                end
            end
        end
        return found;
    endfunction

    always @(posedge clk)
    begin
        rsp_item_t               want;
        rsp_item_t               got;
        cmd_item_t               order;
        int unsigned             total;
        logic signed [VAL_W-1:0] lo, hi;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = rsp.payload;
            if (expected_medians.size() == 0)
            begin
                $display("%0t: result beat with none expected: median_doubled %0d error_flag %0b",
                         $time, got.median_doubled, got.error_flag);
                error_total++;
            end
            else
            begin
                want = expected_medians.pop_front();
                if (got.median_doubled !== want.median_doubled)
                begin
                    $display("%0t: median_doubled expected %0d got %0d",
                             $time, want.median_doubled, got.median_doubled);
                    error_total++;
                end
                if (got.error_flag !== want.error_flag)
                begin
                    $display("%0t: error_flag expected %0b got %0b",
                             $time, want.error_flag, got.error_flag);
                    error_total++;
                end
            end
        end
        if (rst_n && cmd.valid && cmd.ready)
        begin
            order = cmd.payload;
            case (opcode_t'(order.opcode))
                OP_PUSH_A:
                begin
                    if (count_a >= LIST_CAPACITY)
                    begin
                        push_dropped = 1'b1;
                    end
                    else
                    begin
                        list_a[count_a] = order.element_value;
                        count_a++;
                    end
                end
                OP_PUSH_B:
                begin
                    if (count_b >= LIST_CAPACITY)
                    begin
                        push_dropped = 1'b1;
                    end
                    else
                    begin
                        list_b[count_b] = order.element_value;
                        count_b++;
                    end
                end
                OP_MEDIAN:
                begin
                    total = count_a + count_b;
                    want.error_flag = push_dropped || total == 0;
                    want.median_doubled = '0;
                    if (!want.error_flag)
                    begin
                        hi = kth_smallest(total / 2 + 1);
                        lo = total[0] ? hi : kth_smallest(total / 2);
                        want.median_doubled = {lo[VAL_W-1], lo} + {hi[VAL_W-1], hi};
                    end
                    expected_medians.push_back(want);
                    count_a = 0;
                    count_b = 0;
                    push_dropped = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        pending <= expected_medians.size();
        fail_count <= error_total;
    end

endmodule

[bench/tb.sv]
// Testbench top: drives list pushes and median requests into the block and gives the verdict.
module tb
    import mosl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                      CAPACITY   = 1024;
    localparam int                      IDLE_LIMIT = 4000;
    localparam int                      RANDOM_BEATS = 1520;
    localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   idle_on = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   beats_sent = 0;

    mosl_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();
    mosl_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

    median_of_two_sorted_lists #(.LIST_CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    median_checker #(.LIST_CAPACITY(CAPACITY)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input opcode_t op, input logic signed [VAL_W-1:0] val);
        cmd_item_t order;
        order.opcode = op;
        order.element_value = val;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= order;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        if (op != OP_NONE)
        begin
            beats_sent++;
        end
    endtask

    // next ascending value, held at the top of the range
    function automatic longint step_up(longint level, int unsigned max_step);
        longint nxt;
        nxt = level + longint'($urandom_range(0, max_step));
        if (nxt > 64'sd2147483647)
        begin
            nxt = 64'sd2147483647;
        end
        return nxt;
    endfunction

    function automatic longint start_level(int style);
        case (style)
            0:       return longint'(int'($urandom));
            1:       return longint'(int'($urandom));
            2:       return longint'(VAL_MIN);
            default: return longint'(int'($urandom_range(0, 64))) - 32;
        endcase
    endfunction

    task automatic push_run(input opcode_t op, input int n, input longint first,
                            input int unsigned max_step);
        longint level;
        level = first;
        repeat (n)
        begin
            send_beat(op, level[VAL_W-1:0]);
            level = step_up(level, max_step);
        end
    endtask

    // two short lists pushed interleaved, then a median request
    task automatic median_sequence();
        int          n_a, n_b, style;
        int unsigned max_step;
        bit          scramble;
        bit          to_a;
        longint      level_a, level_b;
        style = $urandom_range(0, 3);
        case (style)
            0:       max_step = 32'h1000_0000;
            1:       max_step = 3;
            2:       max_step = $urandom;
            default: max_step = 16;
        endcase
        scramble = ($urandom_range(0, 9) == 0);
        n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        n_b = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0)
        begin
            n_a = 0;
            n_b = 0;
        end
        level_a = start_level(style);
        level_b = start_level(style);
        while (n_a > 0 || n_b > 0)
        begin
            to_a = (n_b == 0) || (n_a > 0 && $urandom_range(0, 1) == 1);
            if (scramble && $urandom_range(0, 3) == 0)
            begin
                send_beat(to_a ? OP_PUSH_A : OP_PUSH_B, $urandom);
            end
            else if (to_a)
            begin
                send_beat(OP_PUSH_A, level_a[VAL_W-1:0]);
                level_a = step_up(level_a, max_step);
            end
            else
            begin
                send_beat(OP_PUSH_B, level_b[VAL_W-1:0]);
                level_b = step_up(level_b, max_step);
            end
            if (to_a)
            begin
                n_a--;
            end
            else
            begin
                n_b--;
            end
            if ($urandom_range(0, 24) == 0)
            begin
                send_beat(OP_NONE, $urandom);
            end
        end
        send_beat(OP_MEDIAN, $urandom);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        send_beat(OP_MEDIAN, 32'sd0);
        send_beat(OP_NONE, 32'shFFFF_FFFF);
        send_beat(OP_PUSH_A, VAL_MIN);
        send_beat(OP_PUSH_B, VAL_MAX);
        send_beat(OP_MEDIAN, 32'sd0);
        send_beat(OP_PUSH_A, VAL_MAX);
        send_beat(OP_PUSH_B, VAL_MAX);
        send_beat(OP_MEDIAN, VAL_MAX);
        send_beat(OP_PUSH_B, VAL_MIN);
        send_beat(OP_PUSH_B, VAL_MIN);
        send_beat(OP_PUSH_A, VAL_MIN);
        send_beat(OP_MEDIAN, VAL_MIN);
        send_beat(OP_PUSH_A, 32'sd5);
        send_beat(OP_MEDIAN, 32'sd0);
        send_beat(OP_PUSH_B, -32'sd7);
        send_beat(OP_PUSH_B, 32'sd3);
        send_beat(OP_MEDIAN, 32'sd0);
        // unsorted lists still run the same selection
        send_beat(OP_PUSH_A, 32'sd100);
        send_beat(OP_PUSH_A, -32'sd50);
        send_beat(OP_PUSH_A, 32'sd7);
        send_beat(OP_PUSH_B, 32'sd0);
        send_beat(OP_PUSH_B, -32'sd3);
        send_beat(OP_MEDIAN, 32'sd0);

        beats_sent = 0;
        repeat (20)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            median_sequence();
        end
        // list A at capacity, full value range; a dropped push must flag the next median
        idle_on = 1'b1;
        push_run(OP_PUSH_A, CAPACITY, longint'(VAL_MIN), 12000000);
        send_beat(OP_PUSH_A, $urandom);
        push_run(OP_PUSH_B, 5, start_level(0), 1 << 20);
        send_beat(OP_MEDIAN, 32'sd0);
        while (beats_sent < RANDOM_BEATS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            median_sequence();
        end
        idle_on = 1'b0;
        repeat (8) median_sequence();
        cmd_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mosl_pkg.sv
rtl/core/mosl_stream_if.sv
rtl/core/mosl_ram.sv
rtl/core/mosl_dp.sv
rtl/core/mosl_ctrl.sv
rtl/core/median_of_two_sorted_lists.sv
bench/median_checker.sv
bench/tb.sv
